@@ src/mrdp_pkg.sv @@
// ----------------------------------------------------------------------------
// mrdp_pkg: shared types and constants for the Modbus response demux parser
// Parser modes, verdict codes, protocol bytes and the bytewise CRC-16 step.
// ----------------------------------------------------------------------------
`default_nettype none

package mrdp_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_LOG   = 2'd1,
    MODE_FRAME = 2'd2
  } mrdp_mode_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_READ_OK   = 3'd1,
    EV_POS_ACK   = 3'd2,
    EV_OTHER_ACK = 3'd3,
    EV_BAD_CRC   = 3'd4,
    EV_BAD_LEN   = 3'd5,
    EV_DROPPED   = 3'd6
  } mrdp_event_t;

  typedef struct packed {
    logic        log_valid;
    logic [7:0]  log_byte;
    mrdp_event_t frame_event;
  } mrdp_result_t;

  localparam logic [7:0]  SOF_BYTE       = 8'hA5;
  localparam logic [7:0]  FC_READ_HOLD   = 8'h03;
  localparam logic [7:0]  FC_WRITE_MULTI = 8'h10;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] POS_ADDR       = 16'd44;
  localparam logic [7:0]  CH_BRACE       = 8'h7D;
  localparam logic [7:0]  CH_NEWLINE     = 8'h0A;
  localparam int          EXC_FRAME_LEN  = 5;
  localparam int          WR_FRAME_LEN   = 8;
  localparam int          RD_OVERHEAD    = 5;

  // One byte through the reflected CRC-16: eight shift/xor steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  // CRC after the start-of-frame byte.
  localparam logic [15:0] CRC_SOF = crc_byte(CRC_INIT, SOF_BYTE);

endpackage

`default_nettype wire

@@ src/modbus_response_demux_parser.sv @@
// ----------------------------------------------------------------------------
// modbus_response_demux_parser: split a mixed log/Modbus RTU byte stream
// Forwards log text and reports one verdict per closed response frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one raw link byte per transfer (in_tdata[7:0]).
//   out_*  : one result per input byte: out_tuser is the log flag, tdata holds
//            the forwarded byte and the frame verdict.
//   cfg_*  : write expected_reg_count (7 bits); cfg_ready is always high.
//            Write only while no byte is in flight.
// Latency: a result appears on out_tvalid in the cycle after its byte is
//   taken. Throughput: one byte per cycle while out_tready is high; the parse
//   step (eight-stage CRC xor chain plus length compare) sits between the
//   parser state and the result register.
// Stall: the result register holds while out_tready is low; in_tready drops
//   only when that register is full and not being drained, so a new byte is
//   taken in the same cycle the held result leaves.
// Reset (rst_n low, synchronous): parser idle, counts cleared, CRC set to
//   all ones, expected_reg_count cleared, result register emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_response_demux_parser #(
  parameter int FRAME_CAPACITY = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] log_byte, [10:8] frame_event, rest 0
  output logic             out_tuser,  // [0] log_valid
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data    // expected_reg_count
);
  import mrdp_pkg::*;

  logic         in_xfer;
  logic [6:0]   exp_reg_count_r;
  mrdp_result_t step_res;
  mrdp_result_t out_res_r;
  logic         out_valid_r;

  // Take a byte whenever the result register is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_reg_count_r <= 7'd0;
    end else if (cfg_valid && cfg_ready) begin
      exp_reg_count_r <= cfg_data;
    end
  end

  // Parser state advances only on an accepted byte.
  mrdp_parse_core #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (in_xfer),
    .in_byte       (in_tdata),
    .exp_reg_count (exp_reg_count_r),
    .result        (step_res)
  );

  // Result register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.log_valid;
  assign out_tdata  = {5'b00000, out_res_r.frame_event, out_res_r.log_byte};

  // A held result must block new bytes.
  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("byte accepted while result register stalled");

  // Non-log results carry a zero byte.
  a_log_byte_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.log_valid) |-> (out_res_r.log_byte == 8'h00))
    else $error("log byte set without log flag");

  // Forwarded log text only ever comes with no verdict or a dropped frame.
  a_log_event : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.log_valid) |->
      (out_res_r.frame_event == EV_NONE || out_res_r.frame_event == EV_DROPPED))
    else $error("log byte paired with a frame verdict");

  // Every accepted byte produces a result on the next cycle.
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted byte produced no result");

endmodule

`default_nettype wire

@@ src/mrdp_parse_core.sv @@
// ----------------------------------------------------------------------------
// mrdp_parse_core: parser state and per-byte decision logic
// Holds mode, frame count, header fields and running CRC; produces one result
// per byte combinationally and advances state when the byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mrdp_parse_core #(
  parameter int FRAME_CAPACITY = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire logic [7:0]            in_byte,
  input  wire logic [6:0]            exp_reg_count,
  output mrdp_pkg::mrdp_result_t     result
);
  import mrdp_pkg::*;

  localparam int FB_W  = $clog2(FRAME_CAPACITY + 1);
  localparam int CMP_W = 10;

  mrdp_mode_t        mode_r, mode_nxt;
  logic [FB_W-1:0]   frame_bytes_r, frame_bytes_nxt;
  logic [7:0]        func_r, func_nxt;
  logic [7:0]        dlen_r, dlen_nxt;
  logic [15:0]       addr_r, addr_nxt;
  logic [15:0]       crc_r, crc_nxt;

  // decode
  logic              is_sof, line_end, full;
  logic [FB_W-1:0]   fb_inc;
  logic [CMP_W-1:0]  fb_ext;
  logic [7:0]        func_upd, dlen_upd;
  logic [15:0]       addr_upd, crc_upd;
  logic              wr_close, rd_close, ex_close, done;
  logic              crc_bad;

  always_comb begin
    is_sof   = (in_byte == SOF_BYTE);
    line_end = (in_byte == CH_BRACE) || (in_byte == CH_NEWLINE);
    full     = (frame_bytes_r >= FB_W'(FRAME_CAPACITY));
    fb_inc   = frame_bytes_r + FB_W'(1);
    fb_ext   = CMP_W'(fb_inc);
    func_upd = (frame_bytes_r == FB_W'(1)) ? in_byte : func_r;
    dlen_upd = (frame_bytes_r == FB_W'(2)) ? in_byte : dlen_r;
    addr_upd = addr_r;
    if (frame_bytes_r == FB_W'(2)) begin
      addr_upd = {in_byte, 8'h00};
    end else if (frame_bytes_r == FB_W'(3)) begin
      addr_upd = {addr_r[15:8], in_byte};
    end
    crc_upd  = crc_byte(crc_r, in_byte);
    crc_bad  = (crc_upd != 16'h0000);
    wr_close = (fb_ext >= CMP_W'(3)) && (func_upd == FC_WRITE_MULTI)
               && (fb_ext >= CMP_W'(WR_FRAME_LEN));
    rd_close = (fb_ext >= CMP_W'(3)) && (func_upd == FC_READ_HOLD)
               && (fb_ext >= CMP_W'(dlen_upd) + CMP_W'(RD_OVERHEAD));
    ex_close = (fb_ext >= CMP_W'(3)) && (func_upd != FC_WRITE_MULTI)
               && (func_upd != FC_READ_HOLD) && func_upd[7]
               && (fb_ext >= CMP_W'(EXC_FRAME_LEN));
    done     = wr_close || rd_close || ex_close;
  end

  // next state
  always_comb begin
    mode_nxt        = mode_r;
    frame_bytes_nxt = frame_bytes_r;
    func_nxt        = func_r;
    dlen_nxt        = dlen_r;
    addr_nxt        = addr_r;
    crc_nxt         = crc_r;
    case (mode_r)
      MODE_FRAME: begin
        if (full) begin
          if (is_sof) begin
            frame_bytes_nxt = FB_W'(1);
            crc_nxt         = CRC_SOF;
          end else if (!line_end) begin
            frame_bytes_nxt = '0;
            crc_nxt         = CRC_INIT;
            mode_nxt        = MODE_LOG;
          end
        end else begin
          func_nxt        = func_upd;
          dlen_nxt        = dlen_upd;
          addr_nxt        = addr_upd;
          crc_nxt         = crc_upd;
          frame_bytes_nxt = fb_inc;
          if (done) begin
            mode_nxt        = MODE_IDLE;
            frame_bytes_nxt = '0;
            crc_nxt         = CRC_INIT;
          end
        end
      end
      MODE_IDLE, MODE_LOG: begin
        if (is_sof) begin
          mode_nxt        = MODE_FRAME;
          frame_bytes_nxt = FB_W'(1);
          crc_nxt         = CRC_SOF;
        end else begin
          mode_nxt = line_end ? MODE_IDLE : MODE_LOG;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    result = '{log_valid: 1'b0, log_byte: 8'h00, frame_event: EV_NONE};
    case (mode_r)
      MODE_FRAME: begin
        if (full) begin
          if (is_sof) begin
            result.frame_event = EV_DROPPED;
          end else begin
            result.log_valid   = 1'b1;
            result.log_byte    = in_byte;
            result.frame_event = line_end ? EV_NONE : EV_DROPPED;
          end
        end else if (wr_close) begin
          if (crc_bad) begin
            result.frame_event = EV_BAD_CRC;
          end else if (addr_upd == POS_ADDR) begin
            result.frame_event = EV_POS_ACK;
          end else begin
            result.frame_event = EV_OTHER_ACK;
          end
        end else if (rd_close) begin
          if (crc_bad) begin
            result.frame_event = EV_BAD_CRC;
          end else if (dlen_upd != {exp_reg_count, 1'b0}) begin
            result.frame_event = EV_BAD_LEN;
          end else begin
            result.frame_event = EV_READ_OK;
          end
        end else if (ex_close) begin
          result.frame_event = EV_DROPPED;
        end
      end
      MODE_IDLE, MODE_LOG: begin
        if (!is_sof) begin
          result.log_valid = 1'b1;
          result.log_byte  = in_byte;
        end
      end
      default: begin
        result.frame_event = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      frame_bytes_r <= '0;
      func_r        <= 8'h00;
      dlen_r        <= 8'h00;
      addr_r        <= 16'h0000;
      crc_r         <= CRC_INIT;
    end else if (step_en) begin
      mode_r        <= mode_nxt;
      frame_bytes_r <= frame_bytes_nxt;
      func_r        <= func_nxt;
      dlen_r        <= dlen_nxt;
      addr_r        <= addr_nxt;
      crc_r         <= crc_nxt;
    end
  end

endmodule

`default_nettype wire
